/* rtl/core/kba_pkg.sv */
// ----------------------------------------------------------------------------
// kba_pkg
// Shared types, constants and key decode functions of the keystroke barcode
// assembler.
// ----------------------------------------------------------------------------
package kba_pkg;

   localparam int STORE_DEPTH_DEF = 64;

   localparam int CHAR_W     = 7;
   localparam int KEY_W      = 8;
   localparam int TIME_W     = 32;
   localparam int GAP_W      = 16;
   localparam int LEN_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 2'd2;

   // register reset values
   localparam logic [GAP_W-1:0] MAX_GAP_RST = 16'd180;
   localparam logic [LEN_W-1:0] MIN_LEN_RST = 7'd7;
   localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd60;

   // virtual-key codes
   localparam logic [KEY_W-1:0] KEY_TAB     = 8'h09;
   localparam logic [KEY_W-1:0] KEY_ENTER   = 8'h0D;
   localparam logic [KEY_W-1:0] KEY_SHIFT   = 8'h10;
   localparam logic [KEY_W-1:0] KEY_MENU    = 8'h12;
   localparam logic [KEY_W-1:0] KEY_LWIN    = 8'h5B;
   localparam logic [KEY_W-1:0] KEY_RWIN    = 8'h5C;
   localparam logic [KEY_W-1:0] KEY_LSHIFT  = 8'hA0;
   localparam logic [KEY_W-1:0] KEY_RMENU   = 8'hA5;
   localparam logic [KEY_W-1:0] KEY_DIGIT0  = 8'h30;
   localparam logic [KEY_W-1:0] KEY_DIGIT9  = 8'h39;
   localparam logic [KEY_W-1:0] KEY_PAD0    = 8'h60;
   localparam logic [KEY_W-1:0] KEY_PAD9    = 8'h69;
   localparam logic [KEY_W-1:0] KEY_A       = 8'h41;
   localparam logic [KEY_W-1:0] KEY_Z       = 8'h5A;
   localparam logic [KEY_W-1:0] KEY_MINUS   = 8'hBD;

   localparam logic [KEY_W-1:0]  LOWER_OFS  = 8'd32;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   function automatic logic is_modifier(input logic [KEY_W-1:0] k);
      return (k >= KEY_SHIFT && k <= KEY_MENU) || k == KEY_LWIN || k == KEY_RWIN ||
             (k >= KEY_LSHIFT && k <= KEY_RMENU);
   endfunction

   // ASCII character of a key, CHAR_NONE when the key has none
   function automatic logic [CHAR_W-1:0] key_to_char(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] t;
      t = KEY_DIGIT0;
      if (k >= KEY_DIGIT0 && k <= KEY_DIGIT9) begin
         t = k;
      end else if (k >= KEY_PAD0 && k <= KEY_PAD9) begin
         t = k - KEY_PAD0 + KEY_DIGIT0;
      end else if (k >= KEY_A && k <= KEY_Z) begin
         t = k + LOWER_OFS;
      end else if (k == KEY_MINUS) begin
         t = {1'b0, ASCII_MINUS};
      end else begin
         t = {1'b0, CHAR_NONE};
      end
      return t[CHAR_W-1:0];
   endfunction

endpackage

/* rtl/core/keystroke_barcode_assembler_core.sv */
// ----------------------------------------------------------------------------
// keystroke_barcode_assembler_core
// Assembles key-down events into scanner-style codes and emits them one
// character per result.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one key event per transfer (code, release flag, ms timestamp).
//   rsp_*  : one character per transfer; rsp_last_char marks the end of a code.
//   csr_*  : register writes (0 max gap, 1 min length, 2 max length), always
//            ready; other indexes are ignored. Write only while idle.
// Timing:
//   A non-terminator key is taken while req_ready stays high.
//   A terminator that emits N characters holds req_ready low until all N
//   are read from the store, one entry per cycle while the pipeline has room
//   (single read port). The first character reaches rsp through the read data
//   and output registers, then one per cycle while rsp_ready is high.
//   A stalled receiver backs up a two-entry pipeline (read data, output
//   register), which stalls the store reads; nothing is dropped. The next key
//   may be taken while the tail of a code is still waiting on rsp.
// Reset:
//   Clears the count, last key time, emit state, read-data valid and output
//   valid; registers return to 180 / 7 / 60. The store needs no clearing.
// ----------------------------------------------------------------------------
module keystroke_barcode_assembler_core #(
   parameter int STORE_DEPTH = kba_pkg::STORE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kba_pkg::KEY_W-1:0]        req_key_code,
   input  logic                             req_key_release,
   input  logic [kba_pkg::TIME_W-1:0]       req_time_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [kba_pkg::CHAR_W-1:0]       rsp_code_char,
   output logic                             rsp_last_char,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kba_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > kba_pkg::LEN_W) ? CNT_W : kba_pkg::LEN_W;

   kba_pkg::state_type state_ff, state_in;

   logic [kba_pkg::GAP_W-1:0]  max_gap_ff, max_gap_in;
   logic [kba_pkg::LEN_W-1:0]  min_len_ff, min_len_in;
   logic [kba_pkg::LEN_W-1:0]  max_len_ff, max_len_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [kba_pkg::TIME_W-1:0] last_time_ff, last_time_in;
   logic [CNT_W-1:0]           emit_len_ff, emit_len_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_last_ff, s1_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [kba_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_fire, key_down, is_term, is_mod;
   logic [kba_pkg::CHAR_W-1:0] key_char;
   logic [kba_pkg::TIME_W-1:0] gap;
   logic                       gap_over, can_append, start_emit;
   logic [CNT_W-1:0]           count_base;
   logic                       rsp_load, rd_en, rd_last;
   logic                       wr_en;
   logic [kba_pkg::CHAR_W-1:0] rd_data;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      max_gap_in = max_gap_ff;
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kba_pkg::CSR_MAX_GAP: max_gap_in = csr_wdata;
            kba_pkg::CSR_MIN_LEN: min_len_in = csr_wdata[kba_pkg::LEN_W-1:0];
            kba_pkg::CSR_MAX_LEN: max_len_in = csr_wdata[kba_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- key decode ----------------
   assign req_fire = req_valid && req_ready;
   assign key_down = req_fire && !req_key_release;
   assign is_term  = (req_key_code == kba_pkg::KEY_ENTER) ||
                     (req_key_code == kba_pkg::KEY_TAB);
   assign is_mod   = kba_pkg::is_modifier(req_key_code);
   assign key_char = kba_pkg::key_to_char(req_key_code);

   // wrapping 32-bit gap
   assign gap        = req_time_ms - last_time_ff;
   assign gap_over   = (count_ff != '0) &&
                       (gap > {{(kba_pkg::TIME_W-kba_pkg::GAP_W){1'b0}}, max_gap_ff});
   assign count_base = gap_over ? '0 : count_ff;
   assign can_append = (CMP_W'(count_base) < CMP_W'(max_len_ff)) &&
                       (CMP_W'(count_base) < CMP_W'(STORE_DEPTH));

   assign start_emit = key_down && is_term && (count_ff != '0) &&
                       (CMP_W'(count_ff) >= CMP_W'(min_len_ff));

   assign wr_en = key_down && !is_term && !is_mod &&
                  (key_char != kba_pkg::CHAR_NONE) && can_append;

   always_comb begin
      count_in     = count_ff;
      last_time_in = last_time_ff;
      if (key_down) begin
         priority if (is_term) begin
            count_in = '0;
         end else if (is_mod) begin
            count_in = count_ff;
         end else begin
            last_time_in = req_time_ms;
            if (key_char == kba_pkg::CHAR_NONE) begin
               count_in = '0;
            end else if (can_append) begin
               count_in = count_base + CNT_W'(1);
            end else begin
               count_in = count_base;
            end
         end
      end
   end

   // ---------------- emit sequencer ----------------
   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign rd_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == emit_len_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kba_pkg::ST_IDLE: begin
            if (start_emit) begin
               state_in = kba_pkg::ST_EMIT;
            end
         end
         kba_pkg::ST_EMIT: begin
            if (rd_en && rd_last) begin
               state_in = kba_pkg::ST_IDLE;
            end
         end
         default: state_in = kba_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         kba_pkg::ST_IDLE: req_ready = 1'b1;
         kba_pkg::ST_EMIT: rd_en     = !s1_valid_ff || rsp_load;
         default: ;
      endcase
   end

   always_comb begin
      emit_len_in = emit_len_ff;
      idx_in      = idx_ff;
      if (start_emit) begin
         emit_len_in = count_ff;
         idx_in      = '0;
      end else if (rd_en) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   // read data stage, then output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
         s1_last_in  = rd_last;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = s1_valid_ff;
         rsp_char_in  = rd_data;
         rsp_last_in  = s1_last_ff;
      end
   end

   kba_char_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_base[ADDR_W-1:0]),
      .wr_data (key_char),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kba_pkg::ST_IDLE;
         max_gap_ff   <= kba_pkg::MAX_GAP_RST;
         min_len_ff   <= kba_pkg::MIN_LEN_RST;
         max_len_ff   <= kba_pkg::MAX_LEN_RST;
         count_ff     <= '0;
         last_time_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_gap_ff   <= max_gap_in;
         min_len_ff   <= min_len_in;
         max_len_ff   <= max_len_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_len_ff <= emit_len_in;
      idx_ff      <= idx_in;
      s1_last_ff  <= s1_last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   // ---------------- assertions ----------------
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(STORE_DEPTH))
      else $error("character count above store depth");

   a_idx_below_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == kba_pkg::ST_EMIT |-> CNT_W'(idx_ff) < emit_len_ff)
      else $error("read index past end of code");

   a_read_has_room: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (!s1_valid_ff || rsp_load))
      else $error("store read would overwrite pending read data");

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      rd_en && rd_last |=> state_ff == kba_pkg::ST_IDLE && s1_valid_ff && s1_last_ff)
      else $error("final read did not close the code");

endmodule

/* rtl/core/kba_char_store.sv */
// ----------------------------------------------------------------------------
// kba_char_store
// Character store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kba_char_store #(
   parameter int STORE_DEPTH = kba_pkg::STORE_DEPTH_DEF,
   localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [kba_pkg::CHAR_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [kba_pkg::CHAR_W-1:0]  rd_data
);

   logic [kba_pkg::CHAR_W-1:0] mem [STORE_DEPTH];
   logic [kba_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb_keystroke_barcode_assembler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keystroke_barcode_assembler_core
// Feeds key events into the barcode assembler and checks every emitted
// character against a scoreboard filled by a cycle-free predictor of the
// code buffer, covering the register extremes and randomized idling on both
// handshake sides.
// ----------------------------------------------------------------------------
module tb_keystroke_barcode_assembler_core;

   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 10;

   localparam logic [kba_pkg::CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam logic [kba_pkg::KEY_W-1:0]     KEY_LOWEST  = 8'h00;
   localparam logic [kba_pkg::KEY_W-1:0]     KEY_HIGHEST = 8'hFF;

   typedef struct packed {
      logic [kba_pkg::CHAR_W-1:0] code;
      logic                       last;
   } code_char_type;

   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           req_valid       = 1'b0;
   logic                           req_ready;
   logic [kba_pkg::KEY_W-1:0]      req_key_code    = '0;
   logic                           req_key_release = 1'b0;
   logic [kba_pkg::TIME_W-1:0]     req_time_ms     = '0;
   logic                           rsp_valid;
   logic                           rsp_ready       = 1'b0;
   logic [kba_pkg::CHAR_W-1:0]     rsp_code_char;
   logic                           rsp_last_char;
   logic                           csr_valid       = 1'b0;
   logic                           csr_ready;
   logic [kba_pkg::CSR_IDX_W-1:0]  csr_index       = '0;
   logic [kba_pkg::CSR_DATA_W-1:0] csr_wdata       = '0;

   // predictor state and register mirror
   logic [kba_pkg::CHAR_W-1:0] char_buf [kba_pkg::STORE_DEPTH_DEF];
   int                         held      = 0;
   logic [kba_pkg::TIME_W-1:0] last_ms   = '0;
   logic [kba_pkg::GAP_W-1:0]  gap_limit = kba_pkg::MAX_GAP_RST;
   logic [kba_pkg::LEN_W-1:0]  min_chars = kba_pkg::MIN_LEN_RST;
   logic [kba_pkg::LEN_W-1:0]  max_chars = kba_pkg::MAX_LEN_RST;
   code_char_type              emitted_chars [$];

   int                         mismatches    = 0;
   int                         send_idle_pct = 17;
   int                         recv_idle_pct = 70;
   int                         items_sent    = 0;
   int                         quiet         = 0;
   logic [kba_pkg::TIME_W-1:0] now_ms        = '0;

   keystroke_barcode_assembler_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_code    (req_key_code),
      .req_key_release (req_key_release),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_char   (rsp_code_char),
      .rsp_last_char   (rsp_last_char),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic modifier_key(input logic [kba_pkg::KEY_W-1:0] k);
      return (k >= kba_pkg::KEY_SHIFT && k <= kba_pkg::KEY_MENU) ||
             k == kba_pkg::KEY_LWIN || k == kba_pkg::KEY_RWIN ||
             (k >= kba_pkg::KEY_LSHIFT && k <= kba_pkg::KEY_RMENU);
   endfunction

   function automatic logic [kba_pkg::CHAR_W-1:0] ascii_of_key(
         input logic [kba_pkg::KEY_W-1:0] k);
      logic [kba_pkg::KEY_W-1:0] v;
      v = {1'b0, kba_pkg::CHAR_NONE};
      if (k >= kba_pkg::KEY_DIGIT0 && k <= kba_pkg::KEY_DIGIT9) begin
         v = k;
      end else if (k >= kba_pkg::KEY_PAD0 && k <= kba_pkg::KEY_PAD9) begin
         v = k - kba_pkg::KEY_PAD0 + kba_pkg::KEY_DIGIT0;
      end else if (k >= kba_pkg::KEY_A && k <= kba_pkg::KEY_Z) begin
         v = k + kba_pkg::LOWER_OFS;
      end else if (k == kba_pkg::KEY_MINUS) begin
         v = {1'b0, kba_pkg::ASCII_MINUS};
      end
      return v[kba_pkg::CHAR_W-1:0];
   endfunction

   // advances the buffer for one accepted key and queues any emitted code
   function automatic void assemble_key(input logic [kba_pkg::KEY_W-1:0] k, input logic rel,
                                        input logic [kba_pkg::TIME_W-1:0] t);
      int                         cap;
      logic [kba_pkg::CHAR_W-1:0] c;
      logic [kba_pkg::TIME_W-1:0] elapsed;
      code_char_type              entry;
      if (rel) return;
      if (k == kba_pkg::KEY_ENTER || k == kba_pkg::KEY_TAB) begin
         if (held >= int'(min_chars)) begin
            for (int i = 0; i < held; i++) begin
               entry.code = char_buf[i];
               entry.last = (i == held - 1);
               emitted_chars.insert(emitted_chars.size(), entry);
            end
         end
         held = 0;
         return;
      end
      if (modifier_key(k)) return;
      elapsed = t - last_ms;
      if (held != 0 && elapsed > {16'd0, gap_limit}) held = 0;
      last_ms = t;
      c = ascii_of_key(k);
      if (c != kba_pkg::CHAR_NONE) begin
         cap = int'(max_chars) < kba_pkg::STORE_DEPTH_DEF ? int'(max_chars)
                                                          : kba_pkg::STORE_DEPTH_DEF;
         if (held < cap) begin
            char_buf[held] = c;
            held++;
         end
      end else begin
         held = 0;
      end
   endfunction

   function automatic void flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s: expected %0h, actual %0h", what, want, got);
   endfunction

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin : rsp_check
      code_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (emitted_chars.size() == 0) begin
            flag_mismatch("unexpected char", -1, int'(rsp_code_char));
         end else begin
            want = emitted_chars.pop_front();
            if (rsp_code_char !== want.code)
               flag_mismatch("code_char", int'(want.code), int'(rsp_code_char));
            if (rsp_last_char !== want.last)
               flag_mismatch("last_char", int'(want.last), int'(rsp_last_char));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("keystroke_barcode_assembler_core verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_key(input logic [kba_pkg::KEY_W-1:0] k, input logic rel,
                           input logic [kba_pkg::TIME_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_key_code    <= k;
      req_key_release <= rel;
      req_time_ms     <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      assemble_key(k, rel, t);
      items_sent++;
   endtask

   task automatic write_reg(input logic [kba_pkg::CSR_IDX_W-1:0] idx,
                            input logic [kba_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      unique case (idx)
         kba_pkg::CSR_MAX_GAP: gap_limit = data;
         kba_pkg::CSR_MIN_LEN: min_chars = data[kba_pkg::LEN_W-1:0];
         kba_pkg::CSR_MAX_LEN: max_chars = data[kba_pkg::LEN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_config(input logic [kba_pkg::GAP_W-1:0] gap,
                               input logic [kba_pkg::LEN_W-1:0] lo,
                               input logic [kba_pkg::LEN_W-1:0] hi);
      write_reg(kba_pkg::CSR_MAX_GAP, gap);
      write_reg(kba_pkg::CSR_MIN_LEN, {{(kba_pkg::CSR_DATA_W-kba_pkg::LEN_W){1'b0}}, lo});
      write_reg(kba_pkg::CSR_MAX_LEN, {{(kba_pkg::CSR_DATA_W-kba_pkg::LEN_W){1'b0}}, hi});
   endtask

   // hold off new keys until every queued char has gone out
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (emitted_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void advance_time(input bit allow_late);
      int unsigned pick;
      pick = $urandom_range(15);
      if (allow_late && pick == 0)
         now_ms = now_ms + gap_limit + 1 + $urandom_range(5000);
      else if (allow_late && pick == 2)
         now_ms = now_ms + gap_limit + 1;
      else if (pick == 1)
         now_ms = now_ms + gap_limit;
      else
         now_ms = now_ms + $urandom_range(gap_limit);
   endfunction

   function automatic logic [kba_pkg::KEY_W-1:0] pick_char_key;
      case ($urandom_range(3))
         0: return kba_pkg::KEY_DIGIT0 + kba_pkg::KEY_W'($urandom_range(9));
         1: return kba_pkg::KEY_PAD0 + kba_pkg::KEY_W'($urandom_range(9));
         2: return kba_pkg::KEY_A + kba_pkg::KEY_W'($urandom_range(25));
         default: return kba_pkg::KEY_MINUS;
      endcase
   endfunction

   // one scanned code: char keys with optional noise, then Enter or Tab if terminate is set
   task automatic type_code(input int n_chars, input int noise_pct, input bit terminate);
      logic [kba_pkg::KEY_W-1:0] k;
      for (int i = 0; i < n_chars; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
               0: begin
                  k = kba_pkg::KEY_W'($urandom_range(255));
                  send_key(k, 1'b1, $urandom());
               end
               1: begin
                  case ($urandom_range(2))
                     0: k = kba_pkg::KEY_SHIFT + kba_pkg::KEY_W'($urandom_range(2));
                     1: k = $urandom_range(1) ? kba_pkg::KEY_LWIN : kba_pkg::KEY_RWIN;
                     default: k = kba_pkg::KEY_LSHIFT + kba_pkg::KEY_W'($urandom_range(5));
                  endcase
                  send_key(k, 1'b0, $urandom());
               end
               2: begin
                  k = kba_pkg::KEY_W'($urandom_range(255));
                  advance_time(1'b1);
                  send_key(k, 1'b0, now_ms);
               end
               default: now_ms = $urandom();   // clock jump, arbitrary wrap distance
            endcase
         end
         advance_time(noise_pct != 0);
         send_key(pick_char_key(), 1'b0, now_ms);
      end
      if (terminate)
         send_key($urandom_range(1) ? kba_pkg::KEY_ENTER : kba_pkg::KEY_TAB, 1'b0, $urandom());
   endtask

   // reset register values: wrap of the timestamp, ignored keys, clearing keys
   task automatic test_reset_defaults;
      now_ms = 32'hFFFF_FFC0;
      send_key(kba_pkg::KEY_DIGIT0, 1'b0, now_ms);
      send_key(kba_pkg::KEY_SHIFT, 1'b0, '0);              // not recorded as key time
      send_key(kba_pkg::KEY_DIGIT9, 1'b0, now_ms + 20);
      send_key(kba_pkg::KEY_A, 1'b1, '0);
      send_key(kba_pkg::KEY_A, 1'b0, now_ms + 40);
      send_key(kba_pkg::KEY_Z, 1'b0, now_ms + 60);
      send_key(kba_pkg::KEY_PAD0, 1'b0, now_ms + 80);      // crosses zero
      send_key(kba_pkg::KEY_PAD9, 1'b0, now_ms + 100);
      send_key(kba_pkg::KEY_MINUS, 1'b0, now_ms + 280);    // gap equals the limit: kept
      send_key(kba_pkg::KEY_ENTER, 1'b1, '0);
      send_key(kba_pkg::KEY_ENTER, 1'b0, 32'hFFFF_FFFF);
      send_key(kba_pkg::KEY_TAB, 1'b0, '0);                // empty buffer
      send_key(kba_pkg::KEY_DIGIT0 + 8'd1, 1'b0, 32'h100);
      send_key(kba_pkg::KEY_A + 8'd2, 1'b0, 32'h110);
      send_key(KEY_LOWEST, 1'b0, 32'h120);                 // no char: clears
      send_key(kba_pkg::KEY_Z, 1'b0, 32'h130);
      send_key(KEY_HIGHEST, 1'b0, 32'h140);
      send_key(kba_pkg::KEY_PAD0 + 8'd3, 1'b0, 32'h150);
      send_key(kba_pkg::KEY_MINUS, 1'b0, 32'h150 + 181);   // one past the limit: restarts
      send_key(kba_pkg::KEY_ENTER, 1'b0, 32'h300);
   endtask

   // shortest codes, one char kept, keys only count with identical timestamps
   task automatic test_single_char_codes;
      wait_idle;
      write_config('0, 7'd1, 7'd1);
      now_ms = $urandom();
      repeat (6) type_code($urandom_range(1, 3), 0, 1'b1);
   endtask

   task automatic test_full_store;
      wait_idle;
      write_config('1, 7'd64, 7'd64);
      type_code(66, 0, 1'b1);
      wait_idle;
      write_reg(kba_pkg::CSR_MAX_LEN, 16'd10);     // min above capacity: nothing emitted
      write_reg(CSR_SPARE, kba_pkg::CSR_DATA_W'($urandom()));
      type_code(12, 0, 1'b1);
      wait_idle;
      write_config(16'd500, 7'd5, 7'd64);
      type_code(4, 0, 1'b1);
      type_code(5, 0, 1'b1);
   endtask

   task automatic test_random_traffic;
      int gap, lo, hi, stop_at;
      for (int round = 0; round < 3; round++) begin
         wait_idle;
         send_idle_pct = (round == 0) ? 17 : (round == 1) ? 70 : 0;
         recv_idle_pct = (round == 0) ? 70 : (round == 1) ? 17 : 0;
         gap = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(20, 300);
         lo  = $urandom_range(1, 8);
         hi  = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(lo, lo + 8);
         write_config(kba_pkg::GAP_W'(gap), kba_pkg::LEN_W'(lo), kba_pkg::LEN_W'(hi));
         now_ms  = $urandom();
         stop_at = items_sent + 42;
         while (items_sent < stop_at)
            type_code($urandom_range(lo > 2 ? lo - 2 : 1, lo + 4), 15, $urandom_range(9) != 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults;
      test_single_char_codes;
      test_full_store;
      test_random_traffic;
      wait_idle;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("keystroke_barcode_assembler_core verification clean");
      end else begin
         $display("keystroke_barcode_assembler_core verification failed");
      end
      $finish;
   end

endmodule
